// ===== src/cfpa_pkg.sv =====
// shared types and constants for the complex fixed-point alu
package cfpa_pkg;
   localparam int DataWidth = 16;
   localparam int FracBits  = 8;
   localparam int ProdWidth = 2 * DataWidth;
   localparam int SumWidth  = ProdWidth + 1;
   localparam int DenWidth  = ProdWidth + 1;
   localparam int QuoWidth  = DataWidth + 2;
   localparam int NumWidth  = SumWidth + FracBits;

   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_SUB = 2'd1;
   localparam logic [1:0] MODE_MUL = 2'd2;
   localparam logic [1:0] MODE_DIV = 2'd3;

   typedef struct packed {
      logic [1:0]                  mode;
      logic signed [DataWidth-1:0] a_re;
      logic signed [DataWidth-1:0] a_im;
      logic signed [DataWidth-1:0] b_re;
      logic signed [DataWidth-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] res_re;
      logic signed [DataWidth-1:0] res_im;
      logic                        overflow;
      logic                        div_by_zero;
   } rsp_type;
endpackage

// ===== src/cfpa_if.sv =====
// valid/ready channel interface
interface cfpa_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== src/complex_fixed_point_alu_top.sv =====
// complex-number alu on q8.8 operands: add, subtract, multiply, divide
// req channel carries mode and two complex operands, rsp channel one result
// with saturated parts, an overflow flag and a divide-by-zero flag.
// every mode goes through the same pipeline, so results leave in order.
// throughput: one item per cycle while the receiver does not stall; the divider is unrolled into one
// restoring step per stage, so each stage does one compare and subtract.
// a zero divisor gives a zero result with div_by_zero set.
// reset clears all valid bits; payload registers are not reset.
// when the receiver stalls the whole pipeline holds; req_ready follows
// rsp_ready or an empty last stage, so no item is lost or repeated.
module complex_fixed_point_alu_top
   import cfpa_pkg::*;
(
   input logic clock,
   input logic reset,
   cfpa_if.sink   req,
   cfpa_if.source rsp
);
   localparam int Steps = QuoWidth;
   localparam int Depth = Steps + 5;

   logic adv;
   logic [Depth-1:0] v_ff, v_in;
   assign adv = !v_ff[Depth-1] || rsp.ready;
   assign req.ready = adv;
   always_comb begin
      v_in = {v_ff[Depth-2:0], req.valid};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // stage 0: register operands, products
   req_type r0_ff;
   logic signed [ProdWidth-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_ff, p_cc_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         r0_ff   <= req.data;
         p_rr_ff <= ProdWidth'(req.data.a_re * req.data.b_re);
         p_ii_ff <= ProdWidth'(req.data.a_im * req.data.b_im);
         p_ri_ff <= ProdWidth'(req.data.a_re * req.data.b_im);
         p_ir_ff <= ProdWidth'(req.data.a_im * req.data.b_re);
         p_bb_ff <= ProdWidth'(req.data.b_re * req.data.b_re);
         p_cc_ff <= ProdWidth'(req.data.b_im * req.data.b_im);
      end
   end

   // stage 1: sums, magnitudes
   logic [1:0]                 m1_ff;
   logic signed [SumWidth-1:0] s_re, s_im;
   logic [SumWidth-1:0]        mag_re_ff, mag_im_ff;
   logic                       neg_re_ff, neg_im_ff;
   logic [DenWidth-1:0]        den_ff;
   always_comb begin
      unique case (r0_ff.mode)
         MODE_ADD: begin
            s_re = SumWidth'(r0_ff.a_re) + SumWidth'(r0_ff.b_re);
            s_im = SumWidth'(r0_ff.a_im) + SumWidth'(r0_ff.b_im);
         end
         MODE_SUB: begin
            s_re = SumWidth'(r0_ff.a_re) - SumWidth'(r0_ff.b_re);
            s_im = SumWidth'(r0_ff.a_im) - SumWidth'(r0_ff.b_im);
         end
         MODE_MUL: begin
            s_re = SumWidth'(p_rr_ff) - SumWidth'(p_ii_ff);
            s_im = SumWidth'(p_ri_ff) + SumWidth'(p_ir_ff);
         end
         default: begin
            s_re = SumWidth'(p_rr_ff) + SumWidth'(p_ii_ff);
            s_im = SumWidth'(p_ir_ff) - SumWidth'(p_ri_ff);
         end
      endcase
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff     <= r0_ff.mode;
         neg_re_ff <= s_re[SumWidth-1];
         neg_im_ff <= s_im[SumWidth-1];
         mag_re_ff <= s_re[SumWidth-1] ? SumWidth'(-s_re) : SumWidth'(s_re);
         mag_im_ff <= s_im[SumWidth-1] ? SumWidth'(-s_im) : SumWidth'(s_im);
         den_ff    <= DenWidth'($unsigned(p_bb_ff)) + DenWidth'($unsigned(p_cc_ff));
      end
   end

   // stage 2: set up divider; non-divide magnitudes are final here
   // quotient bits above QuoWidth only ever mean saturation, so a
   // pre-check flags them and the divider works on QuoWidth bits
   logic                 dz2, big_re, big_im;
   logic [NumWidth-1:0]  nre, nim;
   logic [NumWidth+QuoWidth-1:0] lim;
   assign nre    = NumWidth'(mag_re_ff) << FracBits;
   assign nim    = NumWidth'(mag_im_ff) << FracBits;
   assign lim    = (NumWidth+QuoWidth)'(den_ff) << QuoWidth;
   assign dz2    = (m1_ff == MODE_DIV) && (den_ff == '0);
   assign big_re = (m1_ff == MODE_DIV) && ((NumWidth+QuoWidth)'(nre) >= lim);
   assign big_im = (m1_ff == MODE_DIV) && ((NumWidth+QuoWidth)'(nim) >= lim);

   // divider stages: one restoring step each, msb first
   logic [NumWidth-1:0] rr_ff [Steps+1];
   logic [NumWidth-1:0] ri_ff [Steps+1];
   logic [QuoWidth-1:0] qr_ff [Steps+1];
   logic [QuoWidth-1:0] qi_ff [Steps+1];
   logic [DenWidth-1:0] dd_ff [Steps+1];
   logic [1:0]          mm_ff [Steps+1];
   logic [3:0]          fl_ff [Steps+1];
   always_ff @(posedge clock) begin
      if (adv) begin
         mm_ff[0] <= m1_ff;
         fl_ff[0] <= {neg_re_ff, neg_im_ff, big_re | dz2, big_im | dz2};
         qr_ff[0] <= '0;
         qi_ff[0] <= '0;
         dd_ff[0] <= den_ff;
         if (m1_ff == MODE_DIV) begin
            rr_ff[0] <= nre;
            ri_ff[0] <= nim;
         end else if (m1_ff == MODE_MUL) begin
            rr_ff[0] <= NumWidth'(mag_re_ff >> FracBits);
            ri_ff[0] <= NumWidth'(mag_im_ff >> FracBits);
         end else begin
            rr_ff[0] <= NumWidth'(mag_re_ff);
            ri_ff[0] <= NumWidth'(mag_im_ff);
         end
      end
   end
   for (genvar k = 0; k < Steps; k++) begin : g_div
      localparam int Sh = Steps - 1 - k;
      logic [NumWidth+QuoWidth-1:0] tr, ti;
      logic                         gr, gi;
      assign tr = (NumWidth+QuoWidth)'(dd_ff[k]) << Sh;
      assign ti = tr;
      assign gr = (NumWidth+QuoWidth)'(rr_ff[k]) >= tr;
      assign gi = (NumWidth+QuoWidth)'(ri_ff[k]) >= ti;
      always_ff @(posedge clock) begin
         if (adv) begin
            dd_ff[k+1] <= dd_ff[k];
            mm_ff[k+1] <= mm_ff[k];
            fl_ff[k+1] <= fl_ff[k];
            if (mm_ff[k] == MODE_DIV) begin
               rr_ff[k+1] <= gr ? NumWidth'((NumWidth+QuoWidth)'(rr_ff[k]) - tr) : rr_ff[k];
               ri_ff[k+1] <= gi ? NumWidth'((NumWidth+QuoWidth)'(ri_ff[k]) - ti) : ri_ff[k];
               qr_ff[k+1] <= {qr_ff[k][QuoWidth-2:0], gr};
               qi_ff[k+1] <= {qi_ff[k][QuoWidth-2:0], gi};
            end else begin
               rr_ff[k+1] <= rr_ff[k];
               ri_ff[k+1] <= ri_ff[k];
               qr_ff[k+1] <= qr_ff[k];
               qi_ff[k+1] <= qi_ff[k];
            end
         end
      end
   end

   // last stages: pick magnitude, sign and saturate
   logic [NumWidth-1:0] fm_re, fm_im;
   logic                dz_l, bre, bim, nre_l, nim_l;
   logic [NumWidth-1:0] pos_max;
   assign pos_max = NumWidth'((1 << (DataWidth - 1)) - 1);
   assign dz_l    = (mm_ff[Steps] == MODE_DIV) && fl_ff[Steps][1] && fl_ff[Steps][0]
                    && (dd_ff[Steps] == '0);
   assign nre_l   = fl_ff[Steps][3];
   assign nim_l   = fl_ff[Steps][2];
   assign bre     = fl_ff[Steps][1] && !dz_l;
   assign bim     = fl_ff[Steps][0] && !dz_l;
   assign fm_re   = (mm_ff[Steps] == MODE_DIV) ? NumWidth'(qr_ff[Steps]) : rr_ff[Steps];
   assign fm_im   = (mm_ff[Steps] == MODE_DIV) ? NumWidth'(qi_ff[Steps]) : ri_ff[Steps];

   logic [NumWidth-1:0] fr_ff, fi_ff;
   logic                nr_ff, ni_ff, br_ff, bi_ff, dz_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         fr_ff <= fm_re;
         fi_ff <= fm_im;
         nr_ff <= nre_l;
         ni_ff <= nim_l;
         br_ff <= bre;
         bi_ff <= bim;
         dz_ff <= dz_l;
      end
   end

   function automatic logic [DataWidth:0] sat_part(input logic [NumWidth-1:0] m,
                                                   input logic neg, input logic big);
      logic [DataWidth-1:0] v;
      logic                 o;
      begin
         o = 1'b0;
         if (neg) begin
            if (big || m > pos_max + 1'b1) begin
               v = DataWidth'(1) << (DataWidth - 1);
               o = 1'b1;
            end else begin
               v = DataWidth'(-m);
            end
         end else if (big || m > pos_max) begin
            v = DataWidth'(pos_max);
            o = 1'b1;
         end else begin
            v = DataWidth'(m);
         end
         sat_part = {o, v};
      end
   endfunction

   logic [DataWidth:0] sr, si;
   rsp_type out_ff;
   assign sr = sat_part(fr_ff, nr_ff, br_ff);
   assign si = sat_part(fi_ff, ni_ff, bi_ff);
   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff.res_re      <= dz_ff ? '0 : sr[DataWidth-1:0];
         out_ff.res_im      <= dz_ff ? '0 : si[DataWidth-1:0];
         out_ff.overflow    <= !dz_ff && (sr[DataWidth] || si[DataWidth]);
         out_ff.div_by_zero <= dz_ff;
      end
   end

   assign rsp.valid = v_ff[Depth-1];
   assign rsp.data  = out_ff;
endmodule

// ===== src/cfpa_checker.sv =====
// port-level checks for the complex fixed-point alu
module cfpa_checker
   import cfpa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");
   a_dz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.div_by_zero |-> !rsp_data.overflow
         && rsp_data.res_re == '0 && rsp_data.res_im == '0)
      else $error("divide by zero result not zero");
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");
endmodule

bind complex_fixed_point_alu_top cfpa_checker u_cfpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data)
);

// ===== dv/testbench.sv =====
// self-checking testbench for the complex fixed-point alu
module testbench;
   import cfpa_pkg::*;

   localparam int MaxCycles = 200000;
   localparam int DrainCycles = 40;

   logic clock;
   logic reset;
   cfpa_if #(.payload_type(req_type)) req_ch ();
   cfpa_if #(.payload_type(rsp_type)) rsp_ch ();

   complex_fixed_point_alu_top dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   rsp_type expected_results[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int hold_cycles = 0;
   bit no_idle = 0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // drop fraction bits toward zero
   function automatic longint trunc_frac(longint v);
      return (v < 0) ? -((-v) >>> FracBits) : (v >>> FracBits);
   endfunction

   function automatic longint scaled_quotient(longint num, longint den);
      return (num < 0) ? -(((-num) <<< FracBits) / den) : ((num <<< FracBits) / den);
   endfunction

   function automatic longint clamp_part(longint v, ref logic ovf);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (DataWidth - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         ovf = 1'b1;
         return hi;
      end
      if (v < lo) begin
         ovf = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic rsp_type complex_result(req_type r);
      rsp_type res;
      longint ar, ai, br, bi, re, im, den;
      logic ovf;
      ar = r.a_re;
      ai = r.a_im;
      br = r.b_re;
      bi = r.b_im;
      re = 0;
      im = 0;
      ovf = 1'b0;
      res.div_by_zero = 1'b0;
      case (r.mode)
         MODE_ADD: begin
            re = ar + br;
            im = ai + bi;
         end
         MODE_SUB: begin
            re = ar - br;
            im = ai - bi;
         end
         MODE_MUL: begin
            re = trunc_frac(ar * br - ai * bi);
            im = trunc_frac(ar * bi + ai * br);
         end
         default: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               res.div_by_zero = 1'b1;
            end else begin
               re = scaled_quotient(ar * br + ai * bi, den);
               im = scaled_quotient(ai * br - ar * bi, den);
            end
         end
      endcase
      re = clamp_part(re, ovf);
      im = clamp_part(im, ovf);
      res.res_re = re[DataWidth-1:0];
      res.res_im = im[DataWidth-1:0];
      res.overflow = ovf;
      return res;
   endfunction

   function automatic logic [DataWidth-1:0] random_operand();
      case ($urandom_range(3))
         0: case ($urandom_range(6))
               0: return 16'sh8000;
               1: return 16'sh7fff;
               2: return 16'sh0000;
               3: return 16'sh0001;
               4: return 16'shffff;
               5: return 16'sh0100;
               default: return 16'shff00;
            endcase
         1: return DataWidth'($urandom_range(2047)) - 16'd1024;
         default: return DataWidth'($urandom);
      endcase
   endfunction

   task automatic send_item(req_type it);
      while (!no_idle && $urandom_range(99) < 19) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= it;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_results.push_back(complex_result(it));
   endtask

   task automatic send_op(logic [1:0] m, logic [DataWidth-1:0] ar, logic [DataWidth-1:0] ai,
                          logic [DataWidth-1:0] br, logic [DataWidth-1:0] bi);
      req_type it;
      it.mode = m;
      it.a_re = ar;
      it.a_im = ai;
      it.b_re = br;
      it.b_im = bi;
      send_item(it);
   endtask

   task automatic send_random(logic [1:0] m);
      req_type it;
      it.mode = m;
      it.a_re = random_operand();
      it.a_im = random_operand();
      it.b_re = random_operand();
      it.b_im = random_operand();
      if (m == MODE_DIV && $urandom_range(19) == 0) begin
         it.b_re = '0;
         it.b_im = '0;
      end
      send_item(it);
   endtask

   task automatic test_directed();
      send_op(MODE_ADD, 16'sh0100, 16'sh0200, 16'sh0300, 16'shfc00);
      send_op(MODE_ADD, 16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff);
      send_op(MODE_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_op(MODE_SUB, 16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff);
      send_op(MODE_SUB, 16'sh0500, 16'sh0000, 16'sh0500, 16'sh8000);
      send_op(MODE_MUL, 16'sh0100, 16'sh0100, 16'sh0100, 16'shff00);
      send_op(MODE_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_op(MODE_MUL, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
      send_op(MODE_MUL, 16'shffff, 16'sh0000, 16'sh0001, 16'sh0000);
      send_op(MODE_MUL, 16'sh0003, 16'shfffd, 16'sh0055, 16'sh0011);
      send_op(MODE_DIV, 16'sh0100, 16'sh0000, 16'sh0000, 16'sh0000);
      send_op(MODE_DIV, 16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0000);
      send_op(MODE_DIV, 16'sh0100, 16'sh0000, 16'sh0300, 16'sh0000);
      send_op(MODE_DIV, 16'shff00, 16'sh0000, 16'sh0300, 16'sh0000);
      send_op(MODE_DIV, 16'sh7fff, 16'sh7fff, 16'sh0001, 16'sh0000);
      send_op(MODE_DIV, 16'sh8000, 16'sh8000, 16'sh0000, 16'shffff);
      send_op(MODE_DIV, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_op(MODE_DIV, 16'sh0001, 16'shffff, 16'sh7fff, 16'sh8000);
      send_op(MODE_DIV, 16'sh0123, 16'shf456, 16'sh0012, 16'shff34);
   endtask

   task automatic test_random(int count);
      repeat (count) send_random(2'($urandom_range(3)));
   endtask

   // receiver holds off while items keep coming, pipeline fills and stalls the input
   task automatic test_backpressure();
      hold_cycles = 300;
      repeat (80) send_random(2'($urandom_range(3)));
   endtask

   task automatic test_no_idle();
      no_idle = 1;
      repeat (150) send_random(2'($urandom_range(3)));
      no_idle = 0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= no_idle || ($urandom_range(99) >= 19);
      end
   end

   always @(posedge clock) begin
      rsp_type exp_res;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result %p", rsp_ch.data);
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_ch.data.res_re !== exp_res.res_re || rsp_ch.data.res_im !== exp_res.res_im ||
                rsp_ch.data.overflow !== exp_res.overflow ||
                rsp_ch.data.div_by_zero !== exp_res.div_by_zero) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p actual %p", exp_res, rsp_ch.data);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MaxCycles) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(450);
      test_backpressure();
      test_no_idle();
      test_random(450);
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

// ===== sim.f =====
src/cfpa_pkg.sv
src/cfpa_if.sv
src/complex_fixed_point_alu_top.sv
src/cfpa_checker.sv
dv/testbench.sv
